// ----- rtl/fesp_pkg.sv -----
// Shared types, register indexes, status codes and sector table functions of the span planner.
package fesp_pkg;

   localparam logic [2:0] CSR_FLASH_BASE     = 3'd0;
   localparam logic [2:0] CSR_FLASH_SIZE     = 3'd1;
   localparam logic [2:0] CSR_UNIFORM_PAGES  = 3'd2;
   localparam logic [2:0] CSR_PAGE_SIZE_LOG2 = 3'd3;
   localparam logic [2:0] CSR_GUARD_BEGIN    = 3'd4;
   localparam logic [2:0] CSR_GUARD_END      = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_REFUSED = 2'd2;

   localparam logic [31:0] RESET_FLASH_BASE  = 32'h0800_0000;
   localparam logic [21:0] RESET_FLASH_SIZE  = 22'h08_0000;
   localparam logic [4:0]  RESET_PAGE_LOG2   = 5'd11;

   localparam logic [21:0] MAX_FLASH_BYTES = 22'h20_0000;
   localparam logic [21:0] FALLBACK_BYTES  = 22'h08_0000;
   localparam logic [4:0]  PAGE_LOG2_MIN   = 5'd8;
   localparam logic [4:0]  PAGE_LOG2_MAX   = 5'd16;

   // One decoded sector: offsets are relative to the flash base.
   typedef struct packed {
      logic [12:0] index;
      logic [21:0] base_off;
      logic [21:0] end_off;
      logic [17:0] size;
   } sector_type;

   // Size of a sector of the variable table.
   function automatic logic [17:0] tbl_size_f(input logic [4:0] idx);
      logic [17:0] r;
      if (idx < 5'd4) begin
         r = 18'h0_4000;
      end else if (idx == 5'd4) begin
         r = 18'h1_0000;
      end else begin
         r = 18'h2_0000;
      end
      return r;
   endfunction

   // Exclusive end offset of a sector of the variable table.
   function automatic logic [21:0] tbl_end_f(input logic [4:0] idx);
      logic [21:0] r;
      if (idx < 5'd4) begin
         r = (22'(idx) + 22'd1) << 14;
      end else if (idx == 5'd4) begin
         r = 22'h02_0000;
      end else begin
         r = (22'(idx) - 22'd3) << 17;
      end
      return r;
   endfunction

endpackage

// ----- rtl/fesp_sector_decode.sv -----
// Sector decoder: maps an offset into the flash array onto its page or table sector.
module fesp_sector_decode (
   input  logic                   uniform,
   input  logic [4:0]             page_log2,
   input  logic [31:0]            offset,
   output fesp_pkg::sector_type   sector
);
   import fesp_pkg::*;

   logic [17:0] page_bytes;
   logic [20:0] off_low;
   logic [20:0] page_base;
   logic [4:0]  tbl_idx;
   logic [21:0] tbl_end;
   logic [17:0] tbl_size;

   always_comb begin
      page_bytes = 18'd1 << page_log2;
      off_low    = offset[20:0];
      page_base  = off_low & ~(21'(page_bytes) - 21'd1);

      // Four small sectors, one medium sector, then large sectors of equal size.
      if (offset < 32'h0001_0000) begin
         tbl_idx = {3'b000, offset[15:14]};
      end else if (offset < 32'h0002_0000) begin
         tbl_idx = 5'd4;
      end else begin
         tbl_idx = 5'd4 + {1'b0, offset[20:17]};
      end
      tbl_end  = tbl_end_f(tbl_idx);
      tbl_size = tbl_size_f(tbl_idx);

      if (uniform) begin
         sector.index    = 13'(off_low >> page_log2);
         sector.base_off = {1'b0, page_base};
         sector.end_off  = {1'b0, page_base} + 22'(page_bytes);
         sector.size     = page_bytes;
      end else begin
         sector.index    = {8'b0, tbl_idx};
         sector.base_off = tbl_end - 22'(tbl_size);
         sector.end_off  = tbl_end;
         sector.size     = tbl_size;
      end
   end

endmodule

// ----- rtl/flash_erase_span_planner_top.sv -----
// Flash erase span planner: range check, sector lookup and guard check in a six-stage pipeline.
//
// Requests arrive on the req_ channel (valid/stall): req_req_type selects an erase
// plan (0) or a lookup of one address (1), with a byte address and, for an erase,
// a byte length. Each request yields exactly one word on the rsp_ channel, in
// order: a status, the first and last sector index, the span bounds and the size
// of the last sector. All fields but the status are zero unless the status is OK.
// The user must write settings via csr_ only while no request is in flight (unenforced).
//
// Throughput is one request per cycle while rsp_stall is low. A request runs through
// an input register, three arithmetic stages (address sums, range compares and
// offsets, sector decode), a span-address stage and the output register.
//
// Synchronous reset empties the pipeline and loads the default geometry: table
// mode, 512 KiB at 0x0800_0000, no guard. When the receiver stalls, each stage
// holds its word and bubbles are squeezed out, so req_stall rises only once every
// stage holds a word.
module flash_erase_span_planner_top #(
   parameter int TABLE_SECTORS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_req_type,
   input  logic [31:0] req_address,
   input  logic [31:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_first_index,
   output logic [12:0] rsp_last_index,
   output logic [31:0] rsp_span_base,
   output logic [31:0] rsp_span_end,
   output logic [17:0] rsp_last_size,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fesp_pkg::*;

   // Settings.
   logic [31:0] flash_base_ff;
   logic [21:0] flash_size_ff;
   logic        uniform_ff;
   logic [4:0]  page_log2_ff;
   logic [31:0] guard_begin_ff;
   logic [31:0] guard_end_ff;

   // Geometry derived from the settings and registered; limit_ff is built from array_bytes_ff.
   logic [21:0] array_bytes_ff, array_bytes_in;
   logic [4:0]  lg_ff, lg_in;
   logic        guard_on_ff, guard_on_in;
   logic [32:0] limit_ff;

   logic [21:0] fs_clamped;
   logic [21:0] tbl_bytes;

   // Stage enables.
   logic en1, en2, en3, en4, en5, en_out;

   // Stage 1: input register.
   logic        v1_ff;
   logic        type1_ff;
   logic [31:0] addr1_ff;
   logic [31:0] len1_ff;

   // Stage 2: sums and differences of the address.
   logic        v2_ff;
   logic        type2_ff, zero2_ff, lo_ok2_ff;
   logic [32:0] end2_ff;
   logic [31:0] last2_ff, off_first2_ff;

   // Stage 3: range verdict and the offset of the last byte.
   logic        v3_ff;
   logic        type3_ff, zero3_ff, range_ok3_ff;
   logic [31:0] off_first3_ff, off_last3_ff;
   logic        range_ok3_in;

   // Stage 4: decoded sectors.
   logic        v4_ff;
   logic        type4_ff, zero4_ff, ok4_ff;
   sector_type  first4_ff, last4_ff;
   sector_type  first_sec, last_sec;

   // Stage 5: absolute span bounds.
   logic        v5_ff;
   logic        type5_ff, zero5_ff, ok5_ff;
   logic [12:0] first_idx5_ff, last_idx5_ff;
   logic [17:0] last_size5_ff;
   logic [32:0] span_base5_ff, span_end5_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic [12:0] first_idx_ff, last_idx_ff;
   logic [31:0] span_base_ff, span_end_ff;
   logic [17:0] last_size_ff;
   logic        guard_fail;

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flash_base_ff  <= RESET_FLASH_BASE;
         flash_size_ff  <= RESET_FLASH_SIZE;
         uniform_ff     <= 1'b0;
         page_log2_ff   <= RESET_PAGE_LOG2;
         guard_begin_ff <= 32'd0;
         guard_end_ff   <= 32'd0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FLASH_BASE:     flash_base_ff  <= csr_wdata;
            CSR_FLASH_SIZE:     flash_size_ff  <= csr_wdata[21:0];
            CSR_UNIFORM_PAGES:  uniform_ff     <= csr_wdata[0];
            CSR_PAGE_SIZE_LOG2: page_log2_ff   <= csr_wdata[4:0];
            CSR_GUARD_BEGIN:    guard_begin_ff <= csr_wdata;
            CSR_GUARD_END:      guard_end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The table array is the longest prefix of sectors that fits the flash size, or 512 KiB if none fits.
   always_comb begin
      fs_clamped = (flash_size_ff > MAX_FLASH_BYTES) ? MAX_FLASH_BYTES : flash_size_ff;
      tbl_bytes  = FALLBACK_BYTES;
      for (int k = 0; k < TABLE_SECTORS; k++) begin
         if (tbl_end_f(5'(k)) <= fs_clamped) begin
            tbl_bytes = tbl_end_f(5'(k));
         end
      end
      array_bytes_in = uniform_ff ? fs_clamped : tbl_bytes;

      if (page_log2_ff < PAGE_LOG2_MIN) begin
         lg_in = PAGE_LOG2_MIN;
      end else if (page_log2_ff > PAGE_LOG2_MAX) begin
         lg_in = PAGE_LOG2_MAX;
      end else begin
         lg_in = page_log2_ff;
      end

      guard_on_in = guard_end_ff > guard_begin_ff;
   end

   always_ff @(posedge clock) begin
      array_bytes_ff <= array_bytes_in;
      lg_ff          <= lg_in;
      guard_on_ff    <= guard_on_in;
      limit_ff       <= {1'b0, flash_base_ff} + 33'(array_bytes_ff);
   end

   // A stage moves on when it is empty or its successor moves on.
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en5       = !v5_ff || en_out;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff        <= req_valid;
         if (en2)    v2_ff        <= v1_ff;
         if (en3)    v3_ff        <= v2_ff;
         if (en4)    v4_ff        <= v3_ff;
         if (en5)    v5_ff        <= v4_ff;
         if (en_out) rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         type1_ff <= req_req_type;
         addr1_ff <= req_address;
         len1_ff  <= req_length;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         type2_ff      <= type1_ff;
         zero2_ff      <= !type1_ff && (len1_ff == 32'd0);
         lo_ok2_ff     <= addr1_ff >= flash_base_ff;
         end2_ff       <= {1'b0, addr1_ff} + {1'b0, len1_ff};
         last2_ff      <= addr1_ff + len1_ff - 32'd1;
         off_first2_ff <= addr1_ff - flash_base_ff;
      end
   end

   // With the address at or above the base, an offset below the array size is in range.
   always_comb begin
      if (type2_ff) begin
         range_ok3_in = lo_ok2_ff && (off_first2_ff < {10'b0, array_bytes_ff});
      end else begin
         range_ok3_in = lo_ok2_ff && !end2_ff[32] && (end2_ff <= limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         type3_ff      <= type2_ff;
         zero3_ff      <= zero2_ff;
         range_ok3_ff  <= range_ok3_in;
         off_first3_ff <= off_first2_ff;
         off_last3_ff  <= type2_ff ? off_first2_ff : (last2_ff - flash_base_ff);
      end
   end

   fesp_sector_decode u_first_dec (
      .uniform   (uniform_ff),
      .page_log2 (lg_ff),
      .offset    (off_first3_ff),
      .sector    (first_sec)
   );

   fesp_sector_decode u_last_dec (
      .uniform   (uniform_ff),
      .page_log2 (lg_ff),
      .offset    (off_last3_ff),
      .sector    (last_sec)
   );

   always_ff @(posedge clock) begin
      if (en4) begin
         type4_ff  <= type3_ff;
         zero4_ff  <= zero3_ff;
         ok4_ff    <= range_ok3_ff;
         first4_ff <= first_sec;
         last4_ff  <= last_sec;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         type5_ff      <= type4_ff;
         zero5_ff      <= zero4_ff;
         ok5_ff        <= ok4_ff;
         first_idx5_ff <= first4_ff.index;
         last_idx5_ff  <= last4_ff.index;
         last_size5_ff <= last4_ff.size;
         span_base5_ff <= {1'b0, flash_base_ff} + 33'(first4_ff.base_off);
         span_end5_ff  <= {1'b0, flash_base_ff} + 33'(last4_ff.end_off);
      end
   end

   // The guard window applies to erases only and is compared at full width.
   always_comb begin
      guard_fail = !type5_ff && guard_on_ff &&
                   ((span_base5_ff < {1'b0, guard_begin_ff}) ||
                    (span_end5_ff > {1'b0, guard_end_ff}));
      if (zero5_ff) begin
         status_in = STATUS_EMPTY;
      end else if (!ok5_ff || guard_fail) begin
         status_in = STATUS_REFUSED;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         status_ff <= status_in;
         if (status_in == STATUS_OK) begin
            first_idx_ff <= first_idx5_ff;
            last_idx_ff  <= last_idx5_ff;
            span_base_ff <= span_base5_ff[31:0];
            span_end_ff  <= span_end5_ff[31:0];
            last_size_ff <= last_size5_ff;
         end else begin
            first_idx_ff <= 13'd0;
            last_idx_ff  <= 13'd0;
            span_base_ff <= 32'd0;
            span_end_ff  <= 32'd0;
            last_size_ff <= 18'd0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_first_index = first_idx_ff;
   assign rsp_last_index  = last_idx_ff;
   assign rsp_span_base   = span_base_ff;
   assign rsp_span_end    = span_end_ff;
   assign rsp_last_size   = last_size_ff;

endmodule

// ----- rtl/fesp_checker.sv -----
// Port checker of the span planner and its binding to the top level.
module fesp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [12:0] rsp_first_index,
   input logic [12:0] rsp_last_index,
   input logic [31:0] rsp_span_base,
   input logic [31:0] rsp_span_end,
   input logic [17:0] rsp_last_size
);
   import fesp_pkg::*;

   // A refused or empty word carries nothing but its status.
   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         rsp_first_index == 13'd0 && rsp_last_index == 13'd0 &&
         rsp_span_base == 32'd0 && rsp_span_end == 32'd0 && rsp_last_size == 18'd0)
      else $error("non-OK response carries non-zero fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_EMPTY) ||
                    (rsp_status == STATUS_REFUSED))
      else $error("undefined status code");

   // Sectors and pages are all powers of two in size.
   a_size_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |->
         $onehot(rsp_last_size) && (rsp_last_index >= rsp_first_index))
      else $error("bad sector size or inverted index range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_span_base) && $stable(rsp_span_end))
      else $error("stalled response word changed");

endmodule

bind flash_erase_span_planner_top fesp_checker u_fesp_checker (.*);
